### hdl/spwm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and controller-to-datapath command type.
package spwm_pkg;

    localparam int unsigned CHANNELS    = 4;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned EMIT        = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
    localparam int unsigned CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [15:0] CMD_MAX      = 16'd32767;
    localparam logic [15:0] PERIOD_RESET = 16'd8399;

    // operation codes
    localparam logic [1:0] OP_SET_CMD = 2'd0;
    localparam logic [1:0] OP_SET_CMP = 2'd1;
    localparam logic [1:0] OP_SET_EN  = 2'd2;
    localparam logic [1:0] OP_COMMIT  = 2'd3;

    // status bit positions
    localparam int unsigned ST_ENABLED = 0;
    localparam int unsigned ST_CLAMPED = 1;
    localparam int unsigned ST_REQ_NZ  = 2;
    localparam int unsigned ST_ACT_NZ  = 3;
    localparam int unsigned ST_NEG     = 4;
    localparam int unsigned ST_PENDING = 5;

    typedef struct packed {
        logic            load;    // capture the input item
        logic            mul;     // magnitude * period
        logic            div;     // scale by 1/32767 and write set-command
        logic            apply;   // set-compare / set-enable write
        logic            commit;  // commit channel idx
        logic [CH_W-1:0] idx;
    } t_dp_cmd;

endpackage

### hdl/signed_pwm_with_direction_interlock.sv
`timescale 1ns / 1ps
// Top level: sign-magnitude PWM command table with direction interlock.
//
// An item is taken on a rising edge with start high and busy low. Set-command
// (op 0) holds busy through S_MUL, for the 15x16 magnitude*period multiply,
// then S_DIV, for the divide by 32767 (reciprocal estimate plus one
// correction). Set-compare and set-enable (ops 1, 2) hold busy in S_APPLY.
// Commit (op 3) walks the channels one per cycle and puts one result per
// channel (channels 0..3 at most) on the result ports, each for exactly one
// cycle with o_strobe high, in the cycle after the channel is processed;
// o_last marks the final one. The receiver cannot hold results off, so it
// must take every strobed transfer. A new item may be accepted while the last
// commit result is still on the ports. period_ticks must be written through
// i_cfg_wr_en/i_cfg_wr_data only while idle; the block does not enforce it.
// Items other than commit addressing a channel >= CHANNELS change nothing.
module signed_pwm_with_direction_interlock (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [2:0]         i_channel,
    input  logic signed [31:0] i_command,
    input  logic [15:0]        i_compare_ticks,
    input  logic               i_enable,
    output logic               o_strobe,
    output logic [2:0]         o_out_channel,
    output logic [15:0]        o_active_compare,
    output logic               o_direction_pin,
    output logic [5:0]         o_status,
    output logic               o_enabled_flag,
    output logic signed [16:0] o_signed_value,
    output logic               o_last
);
    import spwm_pkg::*;

    t_dp_cmd dp_cmd;

    // sequencer: accepts items, issues one datapath command per cycle
    spwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .o_busy      (busy),
        .o_cmd       (dp_cmd)
    );

    // channel table, scaling and commit datapath, result register
    spwm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_operation      (i_operation),
        .i_channel        (i_channel),
        .i_command        (i_command),
        .i_compare_ticks  (i_compare_ticks),
        .i_enable         (i_enable),
        .o_strobe         (o_strobe),
        .o_out_channel    (o_out_channel),
        .o_active_compare (o_active_compare),
        .o_direction_pin  (o_direction_pin),
        .o_status         (o_status),
        .o_enabled_flag   (o_enabled_flag),
        .o_signed_value   (o_signed_value),
        .o_last           (o_last)
    );

endmodule

### hdl/spwm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accepts an item, steps the datapath through its operation.
module spwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_operation,
    output logic              o_busy,
    output spwm_pkg::t_dp_cmd o_cmd
);
    import spwm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CH_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    unique case (i_operation)
                        OP_SET_CMD: n_state = S_MUL;
                        OP_SET_CMP: n_state = S_APPLY;
                        OP_SET_EN:  n_state = S_APPLY;
                        OP_COMMIT:  n_state = S_COMMIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_IDLE;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_IDLE;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (r_idx == CH_W'(CHANNELS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/spwm_dp.sv
`timescale 1ns / 1ps
// Datapath: channel table, command scaling and commit logic.
module spwm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spwm_pkg::t_dp_cmd i_cmd,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_channel,
    input  logic signed [31:0] i_command,
    input  logic [15:0]       i_compare_ticks,
    input  logic              i_enable,
    output logic              o_strobe,
    output logic [2:0]        o_out_channel,
    output logic [15:0]       o_active_compare,
    output logic              o_direction_pin,
    output logic [5:0]        o_status,
    output logic              o_enabled_flag,
    output logic signed [16:0] o_signed_value,
    output logic              o_last
);
    import spwm_pkg::*;

    logic [15:0] r_period;

    // captured item
    logic [1:0]  r_op;
    logic [2:0]  r_ch;
    logic [14:0] r_mag;
    logic        r_neg;
    logic        r_clamp;
    logic [15:0] r_cmp_ticks;
    logic        r_en;
    logic [30:0] r_prod;

    // channel table
    logic               r_enabled [CHANNELS];
    logic [5:0]         r_status  [CHANNELS];
    logic signed [16:0] r_signed  [CHANNELS];
    logic [15:0]        r_req     [CHANNELS];
    logic [15:0]        r_app     [CHANNELS];
    logic               r_want    [CHANNELS];
    logic               r_cur     [CHANNELS];

    // output register
    logic               r_strobe;
    logic [2:0]         r_out_channel;
    logic [15:0]        r_out_app;
    logic               r_out_dir;
    logic [5:0]         r_out_status;
    logic               r_out_en;
    logic signed [16:0] r_out_signed;
    logic               r_out_last;

    // magnitude and saturation of the incoming command
    logic [31:0] in_mag32;
    logic        in_big;
    assign in_mag32 = i_command[31] ? (~i_command + 32'd1) : i_command;
    assign in_big   = (in_mag32 > 32'(CMD_MAX));

    // prod / 32767: estimate low by at most one, then one correction
    logic [31:0] div_sum;
    logic [16:0] div_est;
    logic [31:0] div_rem;
    logic [15:0] div_q;
    assign div_sum = {1'b0, r_prod} + 32'(r_prod >> 15);
    assign div_est = div_sum[31:15];
    assign div_rem = {1'b0, r_prod} - {div_est, 15'b0} + 32'(div_est);
    assign div_q   = (div_rem >= 32'(CMD_MAX)) ? 16'(div_est + 17'd1) : div_est[15:0];

    logic            ch_ok;
    logic [CH_W-1:0] wr_idx;
    logic [CH_W-1:0] rd_idx;
    assign ch_ok  = (int'(r_ch) < CHANNELS);
    assign wr_idx = r_ch[CH_W-1:0];
    assign rd_idx = i_cmd.commit ? i_cmd.idx : wr_idx;

    logic        rd_en;
    logic [5:0]  rd_status;
    logic [15:0] rd_req;
    logic [15:0] rd_app;
    logic        rd_want;
    logic        rd_cur;
    assign rd_en     = r_enabled[rd_idx];
    assign rd_status = r_status[rd_idx];
    assign rd_req    = r_req[rd_idx];
    assign rd_app    = r_app[rd_idx];
    assign rd_want   = r_want[rd_idx];
    assign rd_cur    = r_cur[rd_idx];

    // set-compare
    logic [15:0]        cmp_sat;
    logic signed [16:0] cmp_signed;
    logic signed [16:0] cmd_signed;
    assign cmp_sat    = (r_cmp_ticks > r_period) ? r_period : r_cmp_ticks;
    assign cmp_signed = rd_want ? -$signed({1'b0, cmp_sat}) : $signed({1'b0, cmp_sat});
    assign cmd_signed = r_neg ? -$signed({2'b0, r_mag}) : $signed({2'b0, r_mag});

    // commit of one channel, with the direction interlock
    logic [5:0]  cm_st;
    logic [15:0] cm_app;
    logic        cm_cur;
    always_comb begin
        cm_st  = '0;
        cm_app = '0;
        cm_cur = rd_cur;
        if (rd_en) begin
            cm_st[ST_ENABLED] = 1'b1;
            cm_st[ST_CLAMPED] = rd_status[ST_CLAMPED];
            cm_st[ST_REQ_NZ]  = (rd_req != 16'd0);
            if (rd_want != rd_cur) begin
                cm_st[ST_PENDING] = 1'b1;
                if (rd_app != 16'd0) begin
                    cm_app = '0;
                end else begin
                    cm_cur = rd_want;
                    cm_app = rd_req;
                end
            end else begin
                cm_app = rd_req;
            end
            cm_st[ST_ACT_NZ] = (cm_app != 16'd0);
            cm_st[ST_NEG]    = cm_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_ch        <= i_channel;
            r_mag       <= in_big ? CMD_MAX[14:0] : in_mag32[14:0];
            r_neg       <= i_command[31];
            r_clamp     <= in_big;
            r_cmp_ticks <= i_compare_ticks;
            r_en        <= i_enable;
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * r_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_enabled[i] <= 1'b1;
                r_status[i]  <= 6'(1 << ST_ENABLED);
                r_signed[i]  <= '0;
                r_req[i]     <= '0;
                r_app[i]     <= '0;
                r_want[i]    <= 1'b0;
                r_cur[i]     <= 1'b0;
            end
        end else begin
            if (i_cmd.div && ch_ok) begin
                r_signed[wr_idx]             <= cmd_signed;
                r_want[wr_idx]               <= r_neg;
                r_req[wr_idx]                <= div_q;
                r_status[wr_idx][ST_CLAMPED] <= r_clamp;
            end
            if (i_cmd.apply && ch_ok) begin
                unique case (r_op)
                    OP_SET_CMP: begin
                        r_req[wr_idx]    <= cmp_sat;
                        r_app[wr_idx]    <= cmp_sat;
                        r_signed[wr_idx] <= cmp_signed;
                    end
                    OP_SET_EN: begin
                        r_enabled[wr_idx] <= r_en;
                        r_status[wr_idx]  <= r_en ? 6'(1 << ST_ENABLED) : 6'd0;
                        if (!r_en) begin
                            r_req[wr_idx] <= '0;
                            r_app[wr_idx] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_status[i_cmd.idx] <= cm_st;
                r_app[i_cmd.idx]    <= cm_app;
                r_cur[i_cmd.idx]    <= cm_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.commit && (int'(i_cmd.idx) < EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_channel <= 3'(i_cmd.idx);
            r_out_app     <= cm_app;
            r_out_dir     <= cm_cur;
            r_out_status  <= cm_st;
            r_out_en      <= rd_en;
            r_out_signed  <= r_signed[i_cmd.idx];
            r_out_last    <= (int'(i_cmd.idx) == EMIT - 1);
        end
    end

    assign o_strobe         = r_strobe;
    assign o_out_channel    = r_out_channel;
    assign o_active_compare = r_out_app;
    assign o_direction_pin  = r_out_dir;
    assign o_status         = r_out_status;
    assign o_enabled_flag   = r_out_en;
    assign o_signed_value   = r_out_signed;
    assign o_last           = r_out_last;

endmodule
